### src/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and codes for the pixel format converter
// configuration register indexes, format codes and the channel bundles
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 4;
  localparam int unsigned PixelWidth   = 32;
  localparam int unsigned ChanWidth    = 8;

  // configuration register indexes
  typedef enum logic [CfgAddrWidth-1:0] {
    REG_COLOR_SPACE     = 3'd0,
    REG_GREEN_SIX_BITS  = 3'd1,
    REG_BIG_ENDIAN      = 3'd2,
    REG_PAD_POSITION    = 3'd3,
    REG_SEPARATION_MASK = 3'd4
  } reg_index_e;

  // source color spaces, code 3 is unused and yields black
  typedef enum logic [1:0] {
    CS_NATIVE16 = 2'd0,
    CS_RGB8     = 2'd1,
    CS_CMYK8    = 2'd2
  } color_space_e;

  // pad byte position of 8-bit rgb pixels, code 3 means no pad
  typedef enum logic [1:0] {
    PAD_NONE  = 2'd0,
    PAD_FIRST = 2'd1,
    PAD_LAST  = 2'd2
  } pad_position_e;

  typedef struct packed {
    logic [1:0] color_space;
    logic       green_six_bits;
    logic       big_endian;
    logic [1:0] pad_position;
    logic [3:0] separation_mask;
  } cfg_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } bgr_t;

endpackage

### src/pixel_format_to_bgr24.sv
// ----------------------------------------------------------------------------
// pixel_format_to_bgr24: source pixel to 24-bit blue/green/red converter
// decodes native 16-bit, 8-bit rgb and cmyk pixels per the format registers
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   handshake
//  s_axis    in         tdata: pixel_bytes[31:0]; tlast: eol      tvalid/tready
//  m_axis    out        tdata: blue, green, red; tlast: line_done tvalid/tready
//  cfg       in         cfg_addr_i register index, cfg_data_i     cfg_valid/ready
//
//  the path is an input register, the decode logic, then a result register
//  one pixel per clock sustained while the output is not stalled; the input register and the result register
//  each advance whenever the stage after them is empty or being drained
//  while the output is stalled the input register still takes one transaction
//  reset clears the valid flags and restores the format registers; no sweep
//  the configuration port is always ready and writes take effect next cycle
//
module pixel_format_to_bgr24 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfb_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [pfb_pkg::CfgDataWidth-1:0]  cfg_data_i,
  // source pixel stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // [31:0] pixel_bytes
  input  logic                              s_axis_tlast,   // end_of_line
  // converted pixel stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,   // [7:0] blue, [15:8] green,
                                                            // [23:16] red
  output logic                              m_axis_tlast    // line_done
);
  import pfb_pkg::*;

  cfg_t                  cfg;
  bgr_t                  bgr;

  // input stage
  logic                  in_valid_d, in_valid_q;
  logic [PixelWidth-1:0] pixel_q;
  logic                  eol_q;
  logic                  in_load;

  // result stage
  logic                  out_valid_d, out_valid_q;
  bgr_t                  bgr_q;
  logic                  last_q;
  logic                  out_load;

  pfb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result register can take a new pixel when empty or being read this cycle
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  // input register frees up when empty or when its pixel moves on
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (out_load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      pixel_q <= s_axis_tdata;
      eol_q   <= s_axis_tlast;
    end
    if (out_load) begin
      bgr_q  <= bgr;
      last_q <= eol_q;
    end
  end

  // decode between the two registers
  pfb_convert u_convert (
    .cfg_i   (cfg),
    .pixel_i (pixel_q),
    .bgr_o   (bgr)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {bgr_q.red, bgr_q.green, bgr_q.blue};
  assign m_axis_tlast  = last_q;

endmodule

### src/pfb_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfb_cfg_regs: configuration register file
// holds the format registers, written one at a time over the write channel
// ----------------------------------------------------------------------------
module pfb_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfb_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [pfb_pkg::CfgDataWidth-1:0]  cfg_data_i,
  output pfb_pkg::cfg_t                     cfg_o
);
  import pfb_pkg::*;

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_COLOR_SPACE:     cfg_d.color_space     = cfg_data_i[1:0];
        REG_GREEN_SIX_BITS:  cfg_d.green_six_bits  = cfg_data_i[0];
        REG_BIG_ENDIAN:      cfg_d.big_endian      = cfg_data_i[0];
        REG_PAD_POSITION:    cfg_d.pad_position    = cfg_data_i[1:0];
        REG_SEPARATION_MASK: cfg_d.separation_mask = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_space     <= CS_NATIVE16;
      cfg_q.green_six_bits  <= 1'b0;
      cfg_q.big_endian      <= 1'b0;
      cfg_q.pad_position    <= PAD_NONE;
      cfg_q.separation_mask <= 4'hf;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/pfb_convert.sv
// ----------------------------------------------------------------------------
// pfb_convert: pixel decode datapath
// turns one registered source pixel into 8-bit blue, green and red
// ----------------------------------------------------------------------------
module pfb_convert (
  input  pfb_pkg::cfg_t                   cfg_i,
  input  logic [pfb_pkg::PixelWidth-1:0]  pixel_i,
  output pfb_pkg::bgr_t                   bgr_o
);
  import pfb_pkg::*;

  // bit replication of a 5-bit field
  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  // bit replication of a 6-bit field
  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  // (255-x)*(255-k)/255 truncated; exact for products below 2^16
  function automatic logic [7:0] ink_to_level(input logic [7:0] x, input logic [7:0] k);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'h00, ~x} * {8'h00, ~k};
    sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    ink_to_level = sum[15:8];
  endfunction

  logic [15:0] word16;
  logic [23:0] rgb_bytes;
  bgr_t        native_bgr, rgb_bgr, cmyk_bgr;
  logic [7:0]  ink_c, ink_m, ink_y, ink_k;

  // native 16-bit
  assign word16 = cfg_i.big_endian ? {pixel_i[7:0], pixel_i[15:8]} : pixel_i[15:0];

  always_comb begin
    native_bgr.blue = widen5(word16[4:0]);
    if (cfg_i.green_six_bits) begin
      native_bgr.green = widen6(word16[10:5]);
      native_bgr.red   = widen5(word16[15:11]);
    end else begin
      native_bgr.green = widen5(word16[9:5]);
      native_bgr.red   = widen5(word16[14:10]);
    end
  end

  // 8-bit rgb, channels start one byte up behind a leading pad
  assign rgb_bytes = (cfg_i.pad_position == PAD_FIRST) ? pixel_i[31:8] : pixel_i[23:0];

  always_comb begin
    if (cfg_i.big_endian) begin
      rgb_bgr.red   = rgb_bytes[7:0];
      rgb_bgr.green = rgb_bytes[15:8];
      rgb_bgr.blue  = rgb_bytes[23:16];
    end else begin
      rgb_bgr.blue  = rgb_bytes[7:0];
      rgb_bgr.green = rgb_bytes[15:8];
      rgb_bgr.red   = rgb_bytes[23:16];
    end
  end

  // cmyk with separation mask
  assign ink_c = cfg_i.separation_mask[0] ? pixel_i[7:0]   : 8'h00;
  assign ink_m = cfg_i.separation_mask[1] ? pixel_i[15:8]  : 8'h00;
  assign ink_y = cfg_i.separation_mask[2] ? pixel_i[23:16] : 8'h00;
  assign ink_k = cfg_i.separation_mask[3] ? pixel_i[31:24] : 8'h00;

  assign cmyk_bgr.blue  = ink_to_level(ink_y, ink_k);
  assign cmyk_bgr.green = ink_to_level(ink_m, ink_k);
  assign cmyk_bgr.red   = ink_to_level(ink_c, ink_k);

  always_comb begin
    case (cfg_i.color_space)
      CS_NATIVE16: bgr_o = native_bgr;
      CS_RGB8:     bgr_o = rgb_bgr;
      CS_CMYK8:    bgr_o = cmyk_bgr;
      default:     bgr_o = '0;
    endcase
  end

endmodule

### verif/pixel_format_to_bgr24_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_format_to_bgr24_checker: scoreboard for the pixel format converter
// tracks the format registers from the config port, predicts each converted
// pixel at source acceptance and compares it with the result stream in order
// ----------------------------------------------------------------------------
module pixel_format_to_bgr24_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [pfb_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [pfb_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [31:0]                       s_tdata_i,
  input  logic                              s_tlast_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [23:0]                       m_tdata_i,
  input  logic                              m_tlast_i,
  output int unsigned                       fail_cnt_o,
  output int unsigned                       pending_cnt_o
);
  import pfb_pkg::*;

  localparam int unsigned MaxReports = 10;
  localparam int unsigned FullScale  = 255;

  typedef struct packed {
    logic line_done;
    bgr_t bgr;
  } bgr_result_t;

  cfg_t          fmt;
  bgr_result_t   expected_bgr_q[$];
  bgr_result_t   got_bgr;
  bgr_result_t   want_bgr;
  int unsigned   fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] ink_level(input logic [7:0] ink, input logic [7:0] black);
    int unsigned lvl;
    lvl = ((FullScale - ink) * (FullScale - black)) / FullScale;
    return lvl[7:0];
  endfunction

  function automatic bgr_result_t convert_pixel(input cfg_t f, input logic [31:0] px,
                                                input logic eol);
    bgr_result_t res;
    logic [15:0] w;
    logic [31:0] chan;
    logic [7:0]  cyan, magenta, yellow, black;
    res           = '0;
    res.line_done = eol;
    case (f.color_space)
      CS_NATIVE16: begin
        w = f.big_endian ? {px[7:0], px[15:8]} : px[15:0];
        res.bgr.blue = widen5(w[4:0]);
        if (f.green_six_bits) begin
          res.bgr.green = widen6(w[10:5]);
          res.bgr.red   = widen5(w[15:11]);
        end else begin
          res.bgr.green = widen5(w[9:5]);
          res.bgr.red   = widen5(w[14:10]);
        end
      end
      CS_RGB8: begin
        // pad byte in front shifts the channel bytes up by one
        chan = (f.pad_position == PAD_FIRST) ? (px >> 8) : px;
        res.bgr.green = chan[15:8];
        if (f.big_endian) begin
          res.bgr.red  = chan[7:0];
          res.bgr.blue = chan[23:16];
        end else begin
          res.bgr.blue = chan[7:0];
          res.bgr.red  = chan[23:16];
        end
      end
      CS_CMYK8: begin
        cyan    = f.separation_mask[0] ? px[7:0]   : 8'h00;
        magenta = f.separation_mask[1] ? px[15:8]  : 8'h00;
        yellow  = f.separation_mask[2] ? px[23:16] : 8'h00;
        black   = f.separation_mask[3] ? px[31:24] : 8'h00;
        res.bgr.blue  = ink_level(yellow, black);
        res.bgr.green = ink_level(magenta, black);
        res.bgr.red   = ink_level(cyan, black);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt.color_space     <= CS_NATIVE16;
      fmt.green_six_bits  <= 1'b0;
      fmt.big_endian      <= 1'b0;
      fmt.pad_position    <= PAD_NONE;
      fmt.separation_mask <= 4'hf;
      expected_bgr_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_bgr.line_done = m_tlast_i;
        got_bgr.bgr       = bgr_t'(m_tdata_i);
        if (expected_bgr_q.size() == 0) begin
          if (fail_cnt < MaxReports)
            $display("%0t: unexpected pixel b=%02h g=%02h r=%02h last=%0b", $realtime,
                     got_bgr.bgr.blue, got_bgr.bgr.green, got_bgr.bgr.red,
                     got_bgr.line_done);
          fail_cnt++;
        end else begin
          want_bgr = expected_bgr_q.pop_front();
          if (got_bgr.bgr.blue !== want_bgr.bgr.blue ||
              got_bgr.bgr.green !== want_bgr.bgr.green ||
              got_bgr.bgr.red !== want_bgr.bgr.red ||
              got_bgr.line_done !== want_bgr.line_done) begin
            if (fail_cnt < MaxReports)
              $display(
                "%0t: mismatch exp b=%02h g=%02h r=%02h l=%0b got b=%02h g=%02h r=%02h l=%0b",
                $realtime, want_bgr.bgr.blue, want_bgr.bgr.green, want_bgr.bgr.red,
                want_bgr.line_done, got_bgr.bgr.blue, got_bgr.bgr.green,
                got_bgr.bgr.red, got_bgr.line_done);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_bgr_q.push_back(convert_pixel(fmt, s_tdata_i, s_tlast_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_COLOR_SPACE:     fmt.color_space     <= cfg_data_i[1:0];
          REG_GREEN_SIX_BITS:  fmt.green_six_bits  <= cfg_data_i[0];
          REG_BIG_ENDIAN:      fmt.big_endian      <= cfg_data_i[0];
          REG_PAD_POSITION:    fmt.pad_position    <= cfg_data_i[1:0];
          REG_SEPARATION_MASK: fmt.separation_mask <= cfg_data_i;
          default: ;
        endcase
      end
      pending_cnt_o <= expected_bgr_q.size();
    end
  end

endmodule

### verif/pixel_format_to_bgr24_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_format_to_bgr24_tb: stimulus and verdict for the pixel format converter
// directed corner pixels per format, then randomized format phases with
// random source gaps and sink back-pressure; the checker scores every result
// ----------------------------------------------------------------------------
module pixel_format_to_bgr24_tb;
  import pfb_pkg::*;

  localparam int unsigned PipeLatency = 2;     // input register plus result register
  localparam int unsigned StallLimit  = 2000;  // cycles with no transaction at all
  localparam int unsigned NumRegs     = 5;     // indexes from this one up are unmapped
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseItems  = 140;
  localparam logic [1:0]  CsUnused    = 2'd3;  // unused color space decodes to black
  localparam logic [1:0]  PadUnused   = 2'd3;  // unused pad code behaves as no pad

  logic                    clk_i;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrWidth-1:0] cfg_addr_i     = '0;
  logic [CfgDataWidth-1:0] cfg_data_i     = '0;
  logic                    s_axis_tvalid  = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata   = '0;
  logic                    s_axis_tlast   = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready  = 1'b0;
  logic [23:0]             m_axis_tdata;
  logic                    m_axis_tlast;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  pixel_format_to_bgr24 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pixel_format_to_bgr24_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  // sink back-pressure, redrawn every cycle at the current stall rate
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one config transaction; the caller lowers cfg_valid_i after a batch so that
  // back-to-back writes never lower and raise valid in the same step
  task automatic write_format_reg(input logic [CfgAddrWidth-1:0] addr,
                                  input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // hold the source off until every predicted pixel has come out, then let
  // the pipeline settle
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (PipeLatency + 1) @(posedge clk_i);
  endtask

  // reprogram every format register while the converter is idle; unused high
  // data bits are randomized since the registers only keep their own width
  task automatic apply_format(input logic [1:0] cs, input logic green6, input logic be,
                              input logic [1:0] pad, input logic [3:0] mask);
    wait_for_results();
    if ($urandom_range(0, 3) == 0)
      write_format_reg(CfgAddrWidth'(NumRegs + $urandom_range(0, 2)), 4'($urandom));
    write_format_reg(REG_COLOR_SPACE,     {2'($urandom), cs});
    write_format_reg(REG_GREEN_SIX_BITS,  {3'($urandom), green6});
    write_format_reg(REG_BIG_ENDIAN,      {3'($urandom), be});
    write_format_reg(REG_PAD_POSITION,    {2'($urandom), pad});
    write_format_reg(REG_SEPARATION_MASK, mask);
    cfg_valid_i <= 1'b0;
  endtask

  // one source transaction, preceded by random idle cycles
  task automatic send_pixel(input logic [31:0] px, input logic eol);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    logic [31:0] px;
    logic [1:0]  cs;
    logic [3:0]  mask;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 11;
    sink_stall_pct = 81;

    // native 555 little-endian: all zero, all one, full red and blue, top bit ignored
    apply_format(CS_NATIVE16, 1'b0, 1'b0, PAD_NONE, 4'hf);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'h1234_7c1f, 1'b0);
    send_pixel(32'habcd_8000, 1'b1);

    // native 565 big-endian: byte swap and six-bit green
    apply_format(CS_NATIVE16, 1'b1, 1'b1, PAD_NONE, 4'hf);
    send_pixel(32'hffff_ffff, 1'b0);
    send_pixel(32'h0000_f800, 1'b0);
    send_pixel(32'h0000_1ff8, 1'b1);
    send_pixel(32'h5a5a_e007, 1'b0);

    // 8-bit rgb in each pad position and byte order, unused pad code too
    apply_format(CS_RGB8, 1'b0, 1'b0, PAD_NONE, 4'hf);
    send_pixel(32'haa30_2010, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    apply_format(CS_RGB8, 1'b1, 1'b1, PAD_FIRST, 4'hf);
    send_pixel(32'h3020_10ee, 1'b0);
    send_pixel(32'h0000_00ff, 1'b1);
    apply_format(CS_RGB8, 1'b0, 1'b0, PAD_LAST, 4'h0);
    send_pixel(32'h5a33_2211, 1'b0);
    apply_format(CS_RGB8, 1'b0, 1'b1, PadUnused, 4'hf);
    send_pixel(32'h4433_2211, 1'b1);

    // cmyk: paper white, full ink, black only, mixed; byte order and pad are don't care
    apply_format(CS_CMYK8, 1'b1, 1'b1, PAD_FIRST, 4'hf);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 1'b1);
    send_pixel(32'hff00_0000, 1'b0);
    send_pixel(32'h0080_ff7f, 1'b0);
    // separation mask: all inks off, then cyan and yellow only
    apply_format(CS_CMYK8, 1'b0, 1'b0, PAD_NONE, 4'h0);
    send_pixel(32'hffff_ffff, 1'b0);
    apply_format(CS_CMYK8, 1'b0, 1'b0, PAD_NONE, 4'h5);
    send_pixel(32'h80ff_ffff, 1'b1);

    // unused color space gives black but keeps the line mark
    apply_format(CsUnused, 1'b1, 1'b1, PadUnused, 4'hf);
    send_pixel(32'hffff_ffff, 1'b1);

    // random phases: a new format each phase, idling pattern by phase group
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase < NumPhases / 3) begin
        src_idle_pct   = 11;
        sink_stall_pct = 81;
      end else if (phase < 2 * NumPhases / 3) begin
        src_idle_pct   = 81;
        sink_stall_pct = 11;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      cs   = ($urandom_range(0, 9) == 0) ? CsUnused : 2'($urandom_range(0, 2));
      mask = ($urandom_range(0, 1) == 0) ? 4'hf : 4'($urandom);
      apply_format(cs, 1'($urandom), 1'($urandom), 2'($urandom), mask);
      for (int n = 0; n < PhaseItems; n++) begin
        // let the pipeline run dry once per phase
        if (n == PhaseItems / 2)
          wait_for_results();
        px = $urandom;
        // saturate some bytes to hit the ink and channel extremes
        for (int b = 0; b < 4; b++) begin
          if ($urandom_range(0, 3) == 0)
            px[8*b +: 8] = {8{1'($urandom)}};
        end
        send_pixel(px, $urandom_range(0, 7) == 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (PipeLatency + 2) @(posedge clk_i);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
